// File: sv/dmsm_pkg.sv
// ----------------------------------------------------------------------------
// dmsm_pkg
// Shared types, constants and small tables for the dual Montgomery scalar
// multiplier over the field of P = 2^255 - 19.
// ----------------------------------------------------------------------------
package dmsm_pkg;

  localparam int LIMB_COUNT = 9;
  localparam int LIMB_W     = 30;
  localparam int ACC_W      = 32;
  localparam int ACC_DEPTH  = LIMB_COUNT + 2;
  localparam int IDX_W      = 4;
  localparam int SCALAR_W   = 61;
  localparam int STEP_W     = 5;

  localparam logic [LIMB_W-1:0] MONT_M     = 30'd678152731;
  localparam logic [LIMB_W-1:0] P_LIMB_LO  = 30'd1073741805;
  localparam logic [LIMB_W-1:0] P_LIMB_MID = 30'd1073741823;
  localparam logic [LIMB_W-1:0] P_LIMB_HI  = 30'd32767;
  localparam logic [ACC_W-1:0]  RED_ADD    = 32'd19;
  localparam logic [ACC_W-1:0]  RED_TOP    = 32'd32767;
  localparam logic [ACC_W-1:0]  RED_SUB    = 32'd32768;

  localparam logic [IDX_W-1:0]  TOP_IDX    = IDX_W'(LIMB_COUNT - 1);
  localparam logic [STEP_W-1:0] LAST_STEP  = 5'd18;

  // Micro-operations of one lane.
  typedef enum logic [3:0] {
    OP_CLR,     // clear the accumulator
    OP_MAV_LO,  // add V times the low scalar digit
    OP_MAV_HI,  // add V times the high scalar digit
    OP_MDG,     // form the Montgomery digit from limb 0
    OP_MAP,     // add P times the Montgomery digit
    OP_CAR,     // carry pass
    OP_DRP,     // drop the lowest limb
    OP_RED,     // conditional subtraction of P
    OP_NEG,     // add P - V for a negative scalar
    OP_BRW,     // borrow pass
    OP_OUT      // emit the result limbs
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // Control word broadcast from the sequencer to the lanes and the merge stage.
  typedef struct packed {
    logic             run;
    logic             load;
    op_t              op;
    logic [IDX_W-1:0] idx;
  } ctrl_t;

  // Program of the sequencer.
  function automatic op_t step_op(input logic [STEP_W-1:0] step);
    op_t op;
    unique case (step)
      5'd0:    op = OP_CLR;
      5'd1:    op = OP_MAV_LO;
      5'd2:    op = OP_MDG;
      5'd3:    op = OP_MAP;
      5'd4:    op = OP_CAR;
      5'd5:    op = OP_DRP;
      5'd6:    op = OP_MAV_HI;
      5'd7:    op = OP_CAR;
      5'd8:    op = OP_MDG;
      5'd9:    op = OP_MAP;
      5'd10:   op = OP_CAR;
      5'd11:   op = OP_DRP;
      5'd12:   op = OP_RED;
      5'd13:   op = OP_CAR;
      5'd14:   op = OP_NEG;
      5'd15:   op = OP_BRW;
      5'd16:   op = OP_RED;
      5'd17:   op = OP_CAR;
      default: op = OP_OUT;
    endcase
    return op;
  endfunction

  // Last limb index that an operation visits.
  function automatic logic [IDX_W-1:0] op_last_idx(input op_t op);
    logic [IDX_W-1:0] last;
    unique case (op)
      OP_MAV_LO, OP_MAV_HI, OP_MAP:     last = IDX_W'(LIMB_COUNT);
      OP_CAR, OP_RED, OP_NEG, OP_OUT:   last = TOP_IDX;
      OP_BRW:                           last = IDX_W'(LIMB_COUNT - 2);
      default:                          last = '0;
    endcase
    return last;
  endfunction

  // Limbs of P.
  function automatic logic [LIMB_W-1:0] prime_limb(input logic [IDX_W-1:0] i);
    logic [LIMB_W-1:0] limb;
    if (i == '0) begin
      limb = P_LIMB_LO;
    end else if (i == TOP_IDX) begin
      limb = P_LIMB_HI;
    end else begin
      limb = P_LIMB_MID;
    end
    return limb;
  endfunction

endpackage

// File: sv/dmsm_seq.sv
// ----------------------------------------------------------------------------
// dmsm_seq
// Sequencer that steps both lanes through the micro-operation program,
// one limb per cycle.
// ----------------------------------------------------------------------------
module dmsm_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  output logic            busy,
  output dmsm_pkg::ctrl_t ctrl
);

  dmsm_pkg::state_t                  state_r, state_nxt;
  logic [dmsm_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic [dmsm_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  dmsm_pkg::op_t                     op;

  assign op   = dmsm_pkg::step_op(step_r);
  assign busy = (state_r != dmsm_pkg::ST_IDLE);

  assign ctrl.run  = (state_r == dmsm_pkg::ST_RUN);
  assign ctrl.load = go;
  assign ctrl.op   = op;
  assign ctrl.idx  = idx_r;

  // Advance the limb index, then the program step.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      dmsm_pkg::ST_IDLE: begin
        if (go) begin
          state_nxt = dmsm_pkg::ST_RUN;
          step_nxt  = '0;
          idx_nxt   = '0;
        end
      end
      dmsm_pkg::ST_RUN: begin
        if (idx_r == dmsm_pkg::op_last_idx(op)) begin
          idx_nxt = '0;
          if (step_r == dmsm_pkg::LAST_STEP) begin
            state_nxt = dmsm_pkg::ST_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: state_nxt = dmsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmsm_pkg::ST_IDLE;
      step_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// File: sv/dmsm_lane.sv
// ----------------------------------------------------------------------------
// dmsm_lane
// One product lane: a limb-serial multiply-accumulate core with an
// eleven-limb accumulator that computes scalar * V * 2^-60 mod P.
// ----------------------------------------------------------------------------
module dmsm_lane (
  input  logic                              clk,
  input  dmsm_pkg::ctrl_t                   ctrl,
  input  logic signed [dmsm_pkg::SCALAR_W-1:0] scalar,
  input  logic [dmsm_pkg::LIMB_W-1:0]       v_limb,
  output logic [dmsm_pkg::LIMB_W-1:0]       res_limb
);

  logic [dmsm_pkg::ACC_W-1:0]    t_r [dmsm_pkg::ACC_DEPTH];
  logic [dmsm_pkg::ACC_W-1:0]    t_nxt [dmsm_pkg::ACC_DEPTH];
  logic [dmsm_pkg::SCALAR_W-1:0] scal_r;
  logic [dmsm_pkg::LIMB_W:0]     acc_r, acc_nxt;
  logic [dmsm_pkg::LIMB_W-1:0]   m_r, m_nxt;
  logic [dmsm_pkg::ACC_W-1:0]    s_r, s_nxt;

  logic [dmsm_pkg::IDX_W-1:0]    idx, idx_up;
  logic [dmsm_pkg::LIMB_W-1:0]   a_limb, m_sel;
  logic [dmsm_pkg::LIMB_W:0]     acc_in;
  logic [2*dmsm_pkg::LIMB_W-1:0] prod;
  logic [2*dmsm_pkg::LIMB_W:0]   mac;
  logic [61:0]                   dprod;
  logic [dmsm_pkg::ACC_W-1:0]    t_cur, s_base, s_sum, s8, s_diff;
  logic                          neg;

  assign idx    = ctrl.idx;
  assign idx_up = idx + 1'b1;
  assign t_cur  = t_r[idx];
  assign neg    = scal_r[dmsm_pkg::SCALAR_W-1];

  // Multiplier operands: V or P, times a scalar digit or the Montgomery digit.
  assign a_limb = (ctrl.op == dmsm_pkg::OP_MAP) ? dmsm_pkg::prime_limb(idx) : v_limb;
  always_comb begin
    if (ctrl.op == dmsm_pkg::OP_MAV_LO) begin
      m_sel = scal_r[dmsm_pkg::LIMB_W-1:0];
    end else if (ctrl.op == dmsm_pkg::OP_MAV_HI) begin
      m_sel = scal_r[2*dmsm_pkg::LIMB_W-1:dmsm_pkg::LIMB_W];
    end else begin
      m_sel = m_r;
    end
  end

  assign acc_in = (idx == '0) ? '0 : acc_r;
  assign prod   = a_limb * m_sel;
  assign mac    = (2*dmsm_pkg::LIMB_W+1)'(prod) + (2*dmsm_pkg::LIMB_W+1)'(acc_in);
  assign dprod  = t_r[0] * dmsm_pkg::MONT_M;

  // Running sum for the conditional subtraction of P.
  assign s_base = (idx == '0) ? dmsm_pkg::RED_ADD : s_r;
  assign s_sum  = s_base + t_cur;
  assign s8     = s_r + t_r[dmsm_pkg::LIMB_COUNT-1];
  assign s_diff = dmsm_pkg::RED_TOP - s8;

  // One micro-operation per cycle on the accumulator.
  always_comb begin
    t_nxt   = t_r;
    acc_nxt = acc_r;
    m_nxt   = m_r;
    s_nxt   = s_r;
    if (ctrl.run) begin
      unique case (ctrl.op)
        dmsm_pkg::OP_CLR: begin
          for (int k = 0; k < dmsm_pkg::ACC_DEPTH; k++) begin
            t_nxt[k] = '0;
          end
        end
        dmsm_pkg::OP_MAV_LO, dmsm_pkg::OP_MAV_HI, dmsm_pkg::OP_MAP: begin
          if (idx == dmsm_pkg::IDX_W'(dmsm_pkg::LIMB_COUNT)) begin
            t_nxt[idx] = t_cur + dmsm_pkg::ACC_W'(acc_r[dmsm_pkg::LIMB_W-1:0]);
          end else begin
            t_nxt[idx] = t_cur + dmsm_pkg::ACC_W'(mac[dmsm_pkg::LIMB_W-1:0]);
            acc_nxt    = mac[2*dmsm_pkg::LIMB_W:dmsm_pkg::LIMB_W];
          end
        end
        dmsm_pkg::OP_MDG: begin
          m_nxt = dprod[dmsm_pkg::LIMB_W-1:0];
        end
        dmsm_pkg::OP_CAR: begin
          t_nxt[idx]    = {2'b00, t_cur[dmsm_pkg::LIMB_W-1:0]};
          t_nxt[idx_up] = t_r[idx_up] + dmsm_pkg::ACC_W'(t_cur[dmsm_pkg::ACC_W-1:dmsm_pkg::LIMB_W]);
        end
        dmsm_pkg::OP_DRP: begin
          for (int k = 0; k < dmsm_pkg::ACC_DEPTH - 1; k++) begin
            t_nxt[k] = t_r[k+1];
          end
          t_nxt[dmsm_pkg::ACC_DEPTH-1] = '0;
        end
        dmsm_pkg::OP_RED: begin
          if (idx == dmsm_pkg::TOP_IDX) begin
            if (s_diff[dmsm_pkg::ACC_W-1]) begin
              t_nxt[0] = t_r[0] + dmsm_pkg::RED_ADD;
              t_nxt[dmsm_pkg::LIMB_COUNT-1] = t_r[dmsm_pkg::LIMB_COUNT-1] - dmsm_pkg::RED_SUB;
            end
          end else begin
            s_nxt = dmsm_pkg::ACC_W'(s_sum[dmsm_pkg::ACC_W-1:dmsm_pkg::LIMB_W]);
          end
        end
        dmsm_pkg::OP_NEG: begin
          if (neg) begin
            t_nxt[idx] = t_cur + dmsm_pkg::ACC_W'(dmsm_pkg::prime_limb(idx))
                         - dmsm_pkg::ACC_W'(v_limb);
          end
        end
        dmsm_pkg::OP_BRW: begin
          if (t_cur[dmsm_pkg::ACC_W-1]) begin
            t_nxt[idx]    = t_cur + (dmsm_pkg::ACC_W'(1) << dmsm_pkg::LIMB_W);
            t_nxt[idx_up] = t_r[idx_up] - dmsm_pkg::ACC_W'(1);
          end
        end
        dmsm_pkg::OP_OUT: begin
          t_nxt = t_r;
        end
        default: t_nxt = t_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      scal_r <= scalar;
    end
    t_r   <= t_nxt;
    acc_r <= acc_nxt;
    m_r   <= m_nxt;
    s_r   <= s_nxt;
  end

  assign res_limb = t_cur[dmsm_pkg::LIMB_W-1:0];

endmodule

// File: sv/dmsm_merge.sv
// ----------------------------------------------------------------------------
// dmsm_merge
// Merge stage: pairs the limbs of both lanes into one registered result item.
// ----------------------------------------------------------------------------
module dmsm_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dmsm_pkg::ctrl_t             ctrl,
  input  logic [dmsm_pkg::LIMB_W-1:0] u_limb,
  input  logic [dmsm_pkg::LIMB_W-1:0] r_limb,
  output logic                        out_valid,
  output logic [dmsm_pkg::IDX_W-1:0]  out_index,
  output logic [dmsm_pkg::LIMB_W-1:0] out_prod_u_limb,
  output logic [dmsm_pkg::LIMB_W-1:0] out_prod_r_limb,
  output logic                        out_is_last
);

  logic                        valid_r;
  logic                        emit;
  logic [dmsm_pkg::IDX_W-1:0]  index_r;
  logic [dmsm_pkg::LIMB_W-1:0] u_r, r_r;
  logic                        last_r;

  assign emit = ctrl.run && (ctrl.op == dmsm_pkg::OP_OUT);

  // Strobe for one cycle per result item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= emit;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      index_r <= ctrl.idx;
      u_r     <= u_limb;
      r_r     <= r_limb;
      last_r  <= (ctrl.idx == dmsm_pkg::TOP_IDX);
    end
  end

  assign out_valid       = valid_r;
  assign out_index       = index_r;
  assign out_prod_u_limb = u_r;
  assign out_prod_r_limb = r_r;
  assign out_is_last     = last_r;

endmodule

// File: sv/dual_montgomery_scalar_mul_p25519_top.sv
// ----------------------------------------------------------------------------
// dual_montgomery_scalar_mul_p25519_top
// Loads V limb by limb and computes u*V*2^-60 mod P and r*V*2^-60 mod P in
// two parallel lanes driven by one sequencer.
// ----------------------------------------------------------------------------
// Limb items 0..7 are taken one per cycle while busy is low and give no result.
// The limb 8 item starts a run of the limb-serial multiply accumulate
// program; busy is high for all of it.
// The nine results appear at the end of the run, one per cycle;
// the receiver cannot stall them.
// Synchronous active-low reset returns the sequencer to idle and drops the strobe.
module dual_montgomery_scalar_mul_p25519_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [dmsm_pkg::LIMB_W-1:0]          in_v_limb,
  input  logic [dmsm_pkg::IDX_W-1:0]           in_limb_index,
  input  logic signed [dmsm_pkg::SCALAR_W-1:0] in_scalar_u,
  input  logic signed [dmsm_pkg::SCALAR_W-1:0] in_scalar_r,
  output logic                                 out_valid,
  output logic [dmsm_pkg::IDX_W-1:0]           out_index,
  output logic [dmsm_pkg::LIMB_W-1:0]          out_prod_u_limb,
  output logic [dmsm_pkg::LIMB_W-1:0]          out_prod_r_limb,
  output logic                                 out_is_last
);

  logic [dmsm_pkg::LIMB_W-1:0] operand_r [dmsm_pkg::LIMB_COUNT];
  logic                        accept, store, go;
  logic [dmsm_pkg::LIMB_W-1:0] v_sel, u_limb, r_limb;
  dmsm_pkg::ctrl_t             ctrl;

  assign accept = start && !busy;
  assign store  = accept && (in_limb_index < dmsm_pkg::IDX_W'(dmsm_pkg::LIMB_COUNT));
  assign go     = accept && (in_limb_index == dmsm_pkg::TOP_IDX);

  // Operand limb store.
  always_ff @(posedge clk) begin
    if (store) begin
      operand_r[in_limb_index] <= in_v_limb;
    end
  end

  // Both lanes read the same operand limb each cycle.
  assign v_sel = (ctrl.idx < dmsm_pkg::IDX_W'(dmsm_pkg::LIMB_COUNT)) ?
                 operand_r[ctrl.idx] : '0;

  dmsm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  dmsm_lane u_lane_u (
    .clk      (clk),
    .ctrl     (ctrl),
    .scalar   (in_scalar_u),
    .v_limb   (v_sel),
    .res_limb (u_limb)
  );

  dmsm_lane u_lane_r (
    .clk      (clk),
    .ctrl     (ctrl),
    .scalar   (in_scalar_r),
    .v_limb   (v_sel),
    .res_limb (r_limb)
  );

  dmsm_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .u_limb          (u_limb),
    .r_limb          (r_limb),
    .out_valid       (out_valid),
    .out_index       (out_index),
    .out_prod_u_limb (out_prod_u_limb),
    .out_prod_r_limb (out_prod_r_limb),
    .out_is_last     (out_is_last)
  );

endmodule
